FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masked
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, reset masked
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/bqf_pkg.sv
// types, constants and microcode rom of the biquad filter core
// no dependencies
package bqf_pkg;

  localparam int COEF_FRAC    = 20;
  localparam int COEF_ONE     = 1048576;
  localparam int DELAY_W      = 24;
  localparam int OUT_W        = 22;
  localparam int DELAY_LIMIT  = 6553600;
  localparam int OUT_LIMIT    = 1310720;
  localparam int CFG_IDX_W    = 3;
  localparam int NUM_COEF     = 5;
  localparam int STEP_W       = 4;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CS_B0 = 3'd0,
    CS_B1 = 3'd1,
    CS_B2 = 3'd2,
    CS_A1 = 3'd3,
    CS_A2 = 3'd4
  } coef_sel_e;

  typedef enum logic {
    MS_X,
    MS_Y
  } mul_src_e;

  typedef enum logic [2:0] {
    AO_HOLD,
    AO_LD_D1,
    AO_LD_D2,
    AO_LD_HALF,
    AO_ADD,
    AO_SUB
  } acc_op_e;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_Y,
    WB_D1,
    WB_D2_OUT
  } wb_e;

  typedef enum logic [1:0] {
    WT_NONE,
    WT_IN,
    WT_OUT
  } wait_e;

  typedef struct packed {
    logic      mul_en;
    mul_src_e  mul_src;
    coef_sel_e coef_sel;
    acc_op_e   acc_op;
    wb_e       wb;
    wait_e     wait_on;
    logic      jump;
    step_t     target;
  } ctrl_word_t;

  localparam ctrl_word_t CW_NOP = '{
    mul_en: 1'b0, mul_src: MS_X, coef_sel: CS_B0, acc_op: AO_HOLD,
    wb: WB_NONE, wait_on: WT_NONE, jump: 1'b0, target: '0
  };

  // one control word per step
  function automatic ctrl_word_t ucode(step_t s);
    ctrl_word_t cw;
    cw = CW_NOP;
    case (s)
      4'd0: begin
        cw.wait_on = WT_IN;
        cw.acc_op  = AO_LD_D1;
      end
      4'd1: begin
        cw.mul_en   = 1'b1;
        cw.mul_src  = MS_X;
        cw.coef_sel = CS_B0;
      end
      4'd2: begin
        cw.acc_op = AO_ADD;
      end
      4'd3: begin
        cw.wb       = WB_Y;
        cw.acc_op   = AO_LD_D2;
        cw.mul_en   = 1'b1;
        cw.mul_src  = MS_X;
        cw.coef_sel = CS_B1;
      end
      4'd4: begin
        cw.acc_op   = AO_ADD;
        cw.mul_en   = 1'b1;
        cw.mul_src  = MS_Y;
        cw.coef_sel = CS_A1;
      end
      4'd5: begin
        cw.acc_op   = AO_SUB;
        cw.mul_en   = 1'b1;
        cw.mul_src  = MS_X;
        cw.coef_sel = CS_B2;
      end
      4'd6: begin
        cw.wb     = WB_D1;
        cw.acc_op = AO_LD_HALF;
      end
      4'd7: begin
        cw.acc_op   = AO_ADD;
        cw.mul_en   = 1'b1;
        cw.mul_src  = MS_Y;
        cw.coef_sel = CS_A2;
      end
      4'd8: begin
        cw.acc_op = AO_SUB;
      end
      4'd9: begin
        cw.wait_on = WT_OUT;
        cw.wb      = WB_D2_OUT;
        cw.jump    = 1'b1;
        cw.target  = '0;
      end
      default: begin
        cw.jump   = 1'b1;
        cw.target = '0;
      end
    endcase
    return cw;
  endfunction

endpackage

FILE: rtl/biquad_tdf2_filter_core.sv
// biquad filter core, transposed direct form ii, microcoded datapath
// depends on bqf_pkg
//
// channel | signals                              | direction
// --------+--------------------------------------+----------
// input   | in_valid_i, in_ready_o, sample_in_i  | in
// output  | out_valid_o, out_ready_i, sample_out_o | out
// config  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | in
//
// ten microcode steps per word: one input step, eight steps through the shared
// multiplier and accumulator, one output step
// one word in flight; the next word is taken once the output step has run
// the output step holds while the output register is full and not taken
// config writes are taken every cycle; reset loads b0 = 1.0, others zero, delays zero
module biquad_tdf2_filter_core #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [bqf_pkg::OUT_W-1:0]  sample_out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bqf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [COEF_WIDTH-1:0]             cfg_data_i
);
  import bqf_pkg::*;

  localparam int CB_W   = (COEF_WIDTH > 21) ? COEF_WIDTH : 22;
  localparam int M_W    = (((CB_W + SAMPLE_WIDTH - 2) > 43) ?
                           (CB_W + SAMPLE_WIDTH - 2) : 43) + 1;
  localparam int Y_NAT  = M_W - 18;
  localparam int FEED_W = 62 - COEF_WIDTH;
  localparam int Y_W    = (Y_NAT < FEED_W) ? Y_NAT : FEED_W;
  localparam int A_W    = (SAMPLE_WIDTH > Y_W) ? SAMPLE_WIDTH : Y_W;
  localparam int P_W    = A_W + CB_W;
  localparam int ACC_A  = P_W + 1;
  localparam int ACC_B  = (ACC_A > (FEED_W + 21)) ? ACC_A : (FEED_W + 21);
  localparam int ACC_W  = (ACC_B > 46) ? ACC_B : 46;
  localparam int RND_W  = ACC_W - COEF_FRAC;

  localparam logic signed [ACC_W-1:0] HALF =
    ACC_W'(1) << (COEF_FRAC - 1);
  localparam logic signed [RND_W-1:0] FEED_LIM =
    (RND_W'(1) << (61 - COEF_WIDTH)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] DLY_LIM = RND_W'(DELAY_LIMIT);
  localparam logic signed [Y_W-1:0]   OUT_LIM = Y_W'(OUT_LIMIT);

  step_t                      step_q, step_d;
  ctrl_word_t                 cw;
  logic                       go;

  logic signed [CB_W-1:0]     coef_q [NUM_COEF];
  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic signed [Y_W-1:0]      y_q;
  logic signed [DELAY_W-1:0]  d1_q, d2_q;
  logic signed [P_W-1:0]      p_q;
  logic signed [ACC_W-1:0]    acc_q, acc_d;
  logic                       out_valid_q;
  logic signed [OUT_W-1:0]    sample_out_q;

  logic signed [A_W-1:0]      mul_a;
  logic signed [CB_W-1:0]     mul_b;
  logic signed [RND_W-1:0]    rnd;
  logic signed [RND_W-1:0]    y_sat;
  logic signed [RND_W-1:0]    d_sat;
  logic signed [Y_W-1:0]      o_sat;

  assign cw = ucode(step_q);

  always_comb begin
    case (cw.wait_on)
      WT_IN:   go = in_valid_i;
      WT_OUT:  go = !out_valid_q || out_ready_i;
      default: go = 1'b1;
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (go) begin
      step_d = cw.jump ? cw.target : step_q + step_t'(1);
    end
  end

  assign mul_a = (cw.mul_src == MS_Y) ? A_W'(y_q) : A_W'(x_q);
  assign mul_b = coef_q[cw.coef_sel];

  // rounding half-up: acc already carries the half lsb
  assign rnd = acc_q[ACC_W-1:COEF_FRAC];

  always_comb begin
    if (rnd > FEED_LIM) begin
      y_sat = FEED_LIM;
    end else if (rnd < -FEED_LIM) begin
      y_sat = -FEED_LIM;
    end else begin
      y_sat = rnd;
    end
    if (rnd > DLY_LIM) begin
      d_sat = DLY_LIM;
    end else if (rnd < -DLY_LIM) begin
      d_sat = -DLY_LIM;
    end else begin
      d_sat = rnd;
    end
    if (y_q > OUT_LIM) begin
      o_sat = OUT_LIM;
    end else if (y_q < -OUT_LIM) begin
      o_sat = -OUT_LIM;
    end else begin
      o_sat = y_q;
    end
  end

  always_comb begin
    case (cw.acc_op)
      AO_LD_D1:   acc_d = (ACC_W'(d1_q) <<< COEF_FRAC) + HALF;
      AO_LD_D2:   acc_d = (ACC_W'(d2_q) <<< COEF_FRAC) + HALF;
      AO_LD_HALF: acc_d = HALF;
      AO_ADD:     acc_d = acc_q + ACC_W'(p_q);
      AO_SUB:     acc_d = acc_q - ACC_W'(p_q);
      default:    acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
      coef_q[CS_B0] <= CB_W'(COEF_ONE);
      coef_q[CS_B1] <= '0;
      coef_q[CS_B2] <= '0;
      coef_q[CS_A1] <= '0;
      coef_q[CS_A2] <= '0;
    end else begin
      step_q <= step_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CS_B0, CS_B1, CS_B2, CS_A1, CS_A2: begin
            coef_q[cfg_index_i] <= CB_W'($signed(cfg_data_i));
          end
          default: ;
        endcase
      end
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (go) begin
        case (cw.wb)
          WB_D1: d1_q <= DELAY_W'(d_sat);
          WB_D2_OUT: begin
            d2_q        <= DELAY_W'(d_sat);
            out_valid_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  // datapath words, no reset
  always_ff @(posedge clk_i) begin
    if (go) begin
      if (cw.wait_on == WT_IN) begin
        x_q <= sample_in_i;
      end
      if (cw.mul_en) begin
        p_q <= P_W'(mul_a * mul_b);
      end
      acc_q <= acc_d;
      if (cw.wb == WB_Y) begin
        y_q <= Y_W'(y_sat);
      end
      if (cw.wb == WB_D2_OUT) begin
        sample_out_q <= OUT_W'(o_sat);
      end
    end
  end

  assign in_ready_o   = (cw.wait_on == WT_IN);
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign cfg_ready_o  = 1'b1;

endmodule

FILE: rtl/bqf_checker.sv
// port-level checks for the biquad filter core, with bind
// depends on bqf_pkg and assert_macros.svh
`include "assert_macros.svh"

module bqf_checker #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int COEF_WIDTH   = 24
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic signed [SAMPLE_WIDTH-1:0]    sample_in_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [bqf_pkg::OUT_W-1:0]  sample_out_o,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [bqf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input logic [COEF_WIDTH-1:0]             cfg_data_i
);
  import bqf_pkg::*;

  localparam logic signed [OUT_W-1:0] OLIM = OUT_W'(OUT_LIMIT);

  logic out_wait;
  logic in_wait;
  logic out_in_range;
  logic cfg_known;

  assign out_wait     = out_valid_o && !out_ready_i;
  assign in_wait      = in_valid_i && !in_ready_o;
  assign out_in_range = (sample_out_o <= OLIM) && (sample_out_o >= -OLIM);
  assign cfg_known    = !$isunknown({cfg_index_i, cfg_data_i});

  // held word keeps its value
  `AST_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(sample_out_o))

  // offered input word stays put until taken
  `AST_NEXT(a_in_hold, clk_i, rst_ni, in_wait, in_valid_i && $stable(sample_in_i))

  // output stays within the saturation range
  `AST_IMPL(a_out_range, clk_i, rst_ni, out_valid_o, out_in_range)

  // one word in flight at a time
  `AST_NEXT(a_one_word, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)

  // config port never back-pressures, and index and data are known whenever a write is offered
  `AST_IMPL(a_cfg_ready, clk_i, rst_ni, cfg_valid_i, cfg_ready_o && cfg_known)

endmodule

bind biquad_tdf2_filter_core bqf_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH),
  .COEF_WIDTH  (COEF_WIDTH)
) u_bqf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .sample_in_i (sample_in_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .sample_out_o(sample_out_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o),
  .cfg_index_i (cfg_index_i),
  .cfg_data_i  (cfg_data_i)
);
